// ===== hdl/axis_following_error_monitor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the following-error monitor
// Shared property shorthands for the blocks of the monitor.
// ----------------------------------------------------------------------------
`ifndef AXIS_FOLLOWING_ERROR_MONITOR_UNIT_MACROS_SVH
`define AXIS_FOLLOWING_ERROR_MONITOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AFEM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("afem assertion failed");

// next-cycle implication, disabled during reset
`define AFEM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("afem assertion failed");

`endif

// ===== hdl/afem_pkg.sv =====
// ----------------------------------------------------------------------------
// afem_pkg
// Types and constants shared by the following-error monitor blocks.
// ----------------------------------------------------------------------------
package afem_pkg;

   localparam int AXIS_W      = 2;
   localparam int POS_W       = 32;
   localparam int TIME_W      = 32;
   localparam int MAG_W       = 31;
   localparam int CNT_W       = 32;
   localparam int REQ_TUSER_W = 3;
   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 136;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_TOLERANCE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_VELOCITY = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WARN_TIMEOUT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLEAR_HOLD   = 2'd3;

   localparam logic [MAG_W-1:0]  RST_TOLERANCE    = 31'd100;
   localparam logic [POS_W-1:0]  RST_MIN_VELOCITY = 32'd256;
   localparam logic [TIME_W-1:0] RST_WARN_TIMEOUT = 32'd500;
   localparam logic [TIME_W-1:0] RST_CLEAR_HOLD   = 32'd2000;

   localparam logic [1:0] STATUS_CODE_OK    = 2'd0;
   localparam logic [1:0] STATUS_CODE_WARN  = 2'd1;
   localparam logic [1:0] STATUS_CODE_ERROR = 2'd2;

   typedef enum logic [2:0] {
      ST_OK   = 3'b001,
      ST_WARN = 3'b010,
      ST_ERR  = 3'b100
   } status_type;

   typedef struct packed {
      logic [MAG_W-1:0]         tolerance_counts;
      logic signed [POS_W-1:0]  min_active_velocity;
      logic [TIME_W-1:0]        warning_timeout_ms;
      logic [TIME_W-1:0]        error_clear_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic                     cmd;
      logic [AXIS_W-1:0]        axis;
      logic [POS_W-1:0]         deviation;
      logic [MAG_W-1:0]         abs_dev_sat;
      logic                     exceeds;
      logic                     moving;
      logic [TIME_W-1:0]        now_ms;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [POS_W-1:0]  deviation;
      logic [MAG_W-1:0]  peak_deviation;
      logic [CNT_W-1:0]  warning_events;
      logic [CNT_W-1:0]  error_events;
      logic              alarm_raised;
      logic              alarm_cleared;
      logic              any_axis_alarm;
   } rsp_type;

   function automatic logic [1:0] status_code(status_type s);
      logic [1:0] code;
      unique case (s)
         ST_OK:   code = STATUS_CODE_OK;
         ST_WARN: code = STATUS_CODE_WARN;
         ST_ERR:  code = STATUS_CODE_ERROR;
         default: code = STATUS_CODE_OK;
      endcase
      return code;
   endfunction

endpackage

// ===== hdl/afem_front.sv =====
// ----------------------------------------------------------------------------
// afem_front
// Accepts request beats, forms the saturated deviation and classifies it
// against tolerance and motion before queueing it for the back end.
// ----------------------------------------------------------------------------
module afem_front import afem_pkg::*; (
   input  cfg_type                  cfg,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_TUSER_W-1:0]   req_tuser,   // cmd, axis
   input  logic [REQ_TDATA_W-1:0]   req_tdata,   // expected, actual, velocity, now_ms
   input  queue_status_type         q_status,
   output logic                     push,
   output item_type                 push_item
);

   logic [POS_W-1:0]        cmd_pos;
   logic [POS_W-1:0]        meas_pos;
   logic signed [POS_W-1:0] velocity;
   logic [TIME_W-1:0]       now_ms;
   logic [POS_W:0]          diff;
   logic [POS_W-1:0]        dev;
   logic [POS_W-1:0]        abs_dev;

   assign cmd_pos  = req_tdata[31:0];
   assign meas_pos = req_tdata[63:32];
   assign velocity = req_tdata[95:64];
   assign now_ms   = req_tdata[127:96];

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      diff = {meas_pos[POS_W-1], meas_pos}
           - {cmd_pos[POS_W-1], cmd_pos};
      // clamp when the 33-bit difference overflows the signed 32-bit range
      if (diff[POS_W] != diff[POS_W-1]) begin
         dev = diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         dev = diff[POS_W-1:0];
      end
      abs_dev = dev[POS_W-1] ? (~dev + 1'b1) : dev;

      push_item.cmd         = req_tuser[0];
      push_item.axis        = req_tuser[2:1];
      push_item.deviation   = dev;
      push_item.abs_dev_sat = abs_dev[POS_W-1] ? {MAG_W{1'b1}} : abs_dev[MAG_W-1:0];
      push_item.exceeds     = abs_dev > {1'b0, cfg.tolerance_counts};
      push_item.moving      = velocity > cfg.min_active_velocity;
      push_item.now_ms      = now_ms;
   end

endmodule

// ===== hdl/afem_queue.sv =====
// ----------------------------------------------------------------------------
// afem_queue
// Short register queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module afem_queue import afem_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  item_type          push_item,
   input  logic              pop,
   output item_type          pop_item,
   output queue_status_type  q_status
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign pop_item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/afem_back.sv =====
// ----------------------------------------------------------------------------
// afem_back
// Per-axis status machine, peak and event counters; one queued item is
// retired per cycle into the response register unless the response stalls.
// ----------------------------------------------------------------------------
`include "axis_following_error_monitor_unit_macros.svh"

module afem_back import afem_pkg::*; #(
   parameter int NUM_AXES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  queue_status_type  q_status,
   input  item_type          pop_item,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output rsp_type           rsp_data
);

   localparam int IW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   status_type        status_ff [NUM_AXES];
   logic [TIME_W-1:0] start_ff  [NUM_AXES];
   logic [MAG_W-1:0]  peak_ff   [NUM_AXES];
   logic [CNT_W-1:0]  wcnt_ff   [NUM_AXES];
   logic [CNT_W-1:0]  ecnt_ff   [NUM_AXES];

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              in_range;
   logic [IW-1:0]     idx;
   status_type        cur_status, nxt_status;
   logic [TIME_W-1:0] cur_start, nxt_start;
   logic [MAG_W-1:0]  cur_peak, nxt_peak;
   logic [CNT_W-1:0]  cur_wcnt, nxt_wcnt;
   logic [CNT_W-1:0]  cur_ecnt, nxt_ecnt;
   logic [TIME_W-1:0] elapsed;
   logic              raised, cleared;
   logic [NUM_AXES-1:0] cur_err_vec, nxt_err_vec;

   assign pop        = !q_status.empty && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign in_range = 32'(pop_item.axis) < NUM_AXES;
   assign idx      = IW'(pop_item.axis);

   always_comb begin
      if (in_range) begin
         cur_status = status_ff[idx];
         cur_start  = start_ff[idx];
         cur_peak   = peak_ff[idx];
         cur_wcnt   = wcnt_ff[idx];
         cur_ecnt   = ecnt_ff[idx];
      end else begin
         cur_status = ST_OK;
         cur_start  = '0;
         cur_peak   = '0;
         cur_wcnt   = '0;
         cur_ecnt   = '0;
      end
      elapsed    = pop_item.now_ms - cur_start;
      nxt_status = cur_status;
      nxt_start  = cur_start;
      nxt_peak   = cur_peak;
      nxt_wcnt   = cur_wcnt;
      nxt_ecnt   = cur_ecnt;
      raised     = 1'b0;
      cleared    = 1'b0;

      if (pop_item.cmd == CMD_CLEAR) begin
         nxt_status = ST_OK;
         nxt_start  = '0;
         nxt_peak   = '0;
      end else begin
         if (pop_item.abs_dev_sat > cur_peak) begin
            nxt_peak = pop_item.abs_dev_sat;
         end
         unique case (cur_status)
            ST_OK: begin
               if (pop_item.moving && pop_item.exceeds) begin
                  nxt_status = ST_WARN;
                  nxt_start  = pop_item.now_ms;
                  nxt_wcnt   = cur_wcnt + 1'b1;
               end
            end
            ST_WARN: begin
               priority if (!pop_item.exceeds) begin
                  nxt_status = ST_OK;
               end else if (elapsed > cfg.warning_timeout_ms) begin
                  nxt_status = ST_ERR;
                  nxt_ecnt   = cur_ecnt + 1'b1;
                  raised     = 1'b1;
               end else if (!pop_item.moving) begin
                  nxt_status = ST_OK;
               end else begin
                  nxt_status = ST_WARN;
               end
            end
            ST_ERR: begin
               if (!pop_item.exceeds && elapsed > cfg.error_clear_hold_ms) begin
                  nxt_status = ST_OK;
                  cleared    = 1'b1;
               end
            end
            default: nxt_status = ST_OK;
         endcase
      end
   end

   // error flags of all axes, with the addressed axis taken after this step
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         cur_err_vec[i] = (status_ff[i] == ST_ERR);
         if (in_range && idx == IW'(i)) begin
            nxt_err_vec[i] = (nxt_status == ST_ERR);
         end else begin
            nxt_err_vec[i] = cur_err_vec[i];
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (pop) begin
         rsp_in.status         = in_range ? status_code(nxt_status) : STATUS_CODE_OK;
         rsp_in.deviation      = (in_range && pop_item.cmd == CMD_UPDATE) ?
                                 pop_item.deviation : '0;
         rsp_in.peak_deviation = in_range ? nxt_peak : '0;
         rsp_in.warning_events = in_range ? nxt_wcnt : '0;
         rsp_in.error_events   = in_range ? nxt_ecnt : '0;
         rsp_in.alarm_raised   = in_range && raised;
         rsp_in.alarm_cleared  = in_range && cleared;
         rsp_in.any_axis_alarm = |nxt_err_vec;
      end
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            status_ff[i] <= ST_OK;
            start_ff[i]  <= '0;
            peak_ff[i]   <= '0;
            wcnt_ff[i]   <= '0;
            ecnt_ff[i]   <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop && in_range) begin
            status_ff[idx] <= nxt_status;
            start_ff[idx]  <= nxt_start;
            peak_ff[idx]   <= nxt_peak;
            wcnt_ff[idx]   <= nxt_wcnt;
            ecnt_ff[idx]   <= nxt_ecnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   `AFEM_ASSERT_IMPL(a_any_alarm_tracks_state, clock, reset, rsp_valid_ff,
                     rsp_ff.any_axis_alarm == (|cur_err_vec))
   `AFEM_ASSERT_IMPL(a_raised_is_error, clock, reset, rsp_valid_ff && rsp_ff.alarm_raised,
                     rsp_ff.status == STATUS_CODE_ERROR)
   `AFEM_ASSERT_IMPL(a_cleared_is_ok, clock, reset, rsp_valid_ff && rsp_ff.alarm_cleared,
                     rsp_ff.status == STATUS_CODE_OK && !rsp_ff.alarm_raised)
   `AFEM_ASSERT_IMPL(a_pop_needs_item, clock, reset, pop, !q_status.empty)

endmodule

// ===== hdl/axis_following_error_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// axis_following_error_monitor_unit
// Per-axis following-error monitor: deviation, peak and ok/warning/error
// status for each axis, one response beat per request beat.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   req_    | in        | req_tvalid/tready   | tuser: cmd, axis; tdata: positions, vel, time
//   rsp_    | out       | rsp_tvalid/tready   | tdata: status ... any_axis_alarm
//   csr_    | in        | csr_we              | csr_addr, csr_wdata
//
// One request beat per clock is sustained while rsp_tready is high; the back
// end retires one queued item per cycle with all per-axis state held in flip-flops.
// Each request beat passes through a queue entry and then the response register.
// Reset is synchronous and clears all axis state.
// A response stall fills the two-entry queue before req_tready drops.
// ----------------------------------------------------------------------------
module axis_following_error_monitor_unit import afem_pkg::*; #(
   parameter int NUM_AXES = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [0] cmd, [2:1] axis
   input  logic [REQ_TUSER_W-1:0]  req_tuser,
   // [31:0] commanded position, [63:32] measured position,
   // [95:64] velocity, [127:96] now_ms
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [1:0] status, [33:2] deviation, [64:34] peak_deviation,
   // [96:65] warning_events, [128:97] error_events, [129] alarm_raised,
   // [130] alarm_cleared, [131] any_axis_alarm, [135:132] zero
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   queue_status_type  q_status;
   logic              push, pop;
   item_type          push_item, pop_item;
   rsp_type           rsp_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_TOLERANCE:    cfg_in.tolerance_counts    = csr_wdata[MAG_W-1:0];
            CSR_MIN_VELOCITY: cfg_in.min_active_velocity = csr_wdata;
            CSR_WARN_TIMEOUT: cfg_in.warning_timeout_ms  = csr_wdata;
            CSR_CLEAR_HOLD:   cfg_in.error_clear_hold_ms = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance_counts    <= RST_TOLERANCE;
         cfg_ff.min_active_velocity <= RST_MIN_VELOCITY;
         cfg_ff.warning_timeout_ms  <= RST_WARN_TIMEOUT;
         cfg_ff.error_clear_hold_ms <= RST_CLEAR_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   afem_front u_front (
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   afem_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .pop_item   (pop_item),
      .q_status   (q_status)
   );

   afem_back #(
      .NUM_AXES   (NUM_AXES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {4'b0000,
                       rsp_data.any_axis_alarm,
                       rsp_data.alarm_cleared,
                       rsp_data.alarm_raised,
                       rsp_data.error_events,
                       rsp_data.warning_events,
                       rsp_data.peak_deviation,
                       rsp_data.deviation,
                       rsp_data.status};

endmodule
